@@ src/acfcp_pkg.sv @@
`timescale 1ns / 1ps

package acfcp_pkg;

	// Character codes
	localparam logic [7:0] CHAR_0       = 8'h30;
	localparam logic [7:0] CHAR_9       = 8'h39;
	localparam logic [7:0] CHAR_UPPER_A = 8'h41;
	localparam logic [7:0] CHAR_UPPER_F = 8'h46;
	localparam logic [7:0] CHAR_LOWER_A = 8'h61;
	localparam logic [7:0] CHAR_LOWER_F = 8'h66;
	localparam logic [7:0] CMD_STD_DATA = 8'h74;  // t
	localparam logic [7:0] CMD_EXT_DATA = 8'h54;  // T
	localparam logic [7:0] CMD_STD_RTR  = 8'h72;  // r
	localparam logic [7:0] CMD_EXT_RTR  = 8'h52;  // R

	// Command layout
	localparam logic [4:0] COUNT_MAX   = 5'd31;
	localparam logic [7:0] MAX_BYTES   = 8'd8;
	localparam logic [4:0] STD_DLC_POS = 5'd4;
	localparam logic [4:0] EXT_DLC_POS = 5'd9;
	localparam int         NUM_BYTES   = 8;

	// Reply codes
	localparam logic [1:0] REPLY_OK    = 2'd0;
	localparam logic [1:0] REPLY_ERR   = 2'd1;
	localparam logic [1:0] REPLY_EMPTY = 2'd2;

	typedef struct packed {
		logic [7:0] character;
		logic       end_of_command;
		logic       empty_command;
	} acfcp_item_t;

	typedef struct packed {
		logic [1:0]  reply_code;
		logic        frame_valid;
		logic [31:0] frame_id;
		logic        frame_extended;
		logic        frame_remote;
		logic [3:0]  frame_length;
		logic [63:0] frame_data;
	} acfcp_result_t;

	function automatic logic [3:0] hex_nibble(input logic [7:0] c);
		logic [7:0] d;
		d = 8'd0;
		case (c) inside
			[CHAR_0:CHAR_9]:             d = c - CHAR_0;
			[CHAR_UPPER_A:CHAR_UPPER_F]: d = c - CHAR_UPPER_A + 8'd10;
			[CHAR_LOWER_A:CHAR_LOWER_F]: d = c - CHAR_LOWER_A + 8'd10;
			default:                     d = 8'd0;
		endcase
		return d[3:0];
	endfunction

	function automatic logic is_ext(input logic [7:0] l);
		return (l == CMD_EXT_DATA) || (l == CMD_EXT_RTR);
	endfunction

endpackage

@@ src/acfcp_accum.sv @@
`timescale 1ns / 1ps

module acfcp_accum (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   step,
	input  acfcp_pkg::acfcp_item_t item,
	output acfcp_pkg::acfcp_result_t result
);
	import acfcp_pkg::*;

	logic [7:0]  first_q, n_first;
	logic [4:0]  count_q, n_count;
	logic [31:0] id_q, n_id;
	logic [7:0]  dlc_q, n_dlc;
	logic [63:0] data_q, n_data;
	logic [3:0]  hold_q, n_hold;

	logic        take;
	logic [3:0]  nib;
	logic [4:0]  dpos;
	logic [4:0]  off;
	logic [3:0]  idx;

	logic        known_cmd;
	logic        r_ext;
	logic        r_rtr;
	logic [4:0]  r_hdr;
	logic [5:0]  r_need;
	logic        r_ok;

	assign take = step && !item.empty_command;
	assign nib  = hex_nibble(item.character);
	assign dpos = is_ext(first_q) ? EXT_DLC_POS : STD_DLC_POS;
	assign off  = count_q - dpos - 5'd1;
	assign idx  = off[4:1];

	// Next state: fold one character into the accumulators
	always_comb begin
		n_first = first_q;
		n_count = count_q;
		n_id    = id_q;
		n_dlc   = dlc_q;
		n_data  = data_q;
		n_hold  = hold_q;
		if (take && count_q != COUNT_MAX) begin
			n_count = count_q + 5'd1;
			if (count_q == 5'd0) begin
				n_first = item.character;
			end else if (count_q < dpos) begin
				n_id = {id_q[27:0], nib};
			end else if (count_q == dpos) begin
				n_dlc = item.character - CHAR_0;
			end else if (!off[0]) begin
				n_hold = nib;
			end else begin
				for (int b = 0; b < NUM_BYTES; b++) begin
					if (idx == 4'(b)) begin
						n_data[8*b +: 8] = data_q[8*b +: 8] | {hold_q, nib};
					end
				end
			end
		end
	end

	// Verdict on the updated state
	always_comb begin
		known_cmd = (n_first == CMD_STD_DATA) || (n_first == CMD_EXT_DATA) ||
		            (n_first == CMD_STD_RTR)  || (n_first == CMD_EXT_RTR);
		r_ext  = is_ext(n_first);
		r_rtr  = (n_first == CMD_STD_RTR) || (n_first == CMD_EXT_RTR);
		r_hdr  = (r_ext ? EXT_DLC_POS : STD_DLC_POS) + 5'd1;
		r_need = {1'b0, n_dlc[3:0], 1'b0} + {1'b0, r_hdr};
		if (n_count < r_hdr) begin
			r_ok = 1'b0;
		end else if (n_dlc > MAX_BYTES) begin
			r_ok = 1'b0;
		end else if (r_rtr) begin
			r_ok = (n_count == r_hdr);
		end else begin
			r_ok = ({1'b0, n_count} == r_need);
		end

		result = '0;
		if (n_count == 5'd0) begin
			result.reply_code = REPLY_EMPTY;
		end else if (!known_cmd) begin
			result.reply_code = REPLY_OK;
		end else if (!r_ok) begin
			result.reply_code = REPLY_ERR;
		end else begin
			result.reply_code     = REPLY_OK;
			result.frame_valid    = 1'b1;
			result.frame_id       = r_ext ? n_id : {20'd0, n_id[11:0]};
			result.frame_extended = r_ext;
			result.frame_remote   = r_rtr;
			result.frame_length   = n_dlc[3:0];
			result.frame_data     = r_rtr ? 64'd0 : n_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_q <= '0;
			count_q <= '0;
			id_q    <= '0;
			dlc_q   <= '0;
			data_q  <= '0;
			hold_q  <= '0;
		end else if (step) begin
			if (item.end_of_command) begin
				first_q <= '0;
				count_q <= '0;
				id_q    <= '0;
				dlc_q   <= '0;
				data_q  <= '0;
				hold_q  <= '0;
			end else begin
				first_q <= n_first;
				count_q <= n_count;
				id_q    <= n_id;
				dlc_q   <= n_dlc;
				data_q  <= n_data;
				hold_q  <= n_hold;
			end
		end
	end

endmodule

@@ src/ascii_can_frame_command_parser.sv @@
`timescale 1ns / 1ps
// A result reaches the output once the transaction that carries the end marker has loaded
// the input register and then, when the result register has room, the result register.
// Throughput: one character per cycle while the result register is not blocked; the
// accumulator update lies between the input register and the result register, and an end
// marker waits in the input register while a stalled result still occupies the output.
// Reset: arst_n clears all valid flags and the command accumulators to zero.

module ascii_can_frame_command_parser (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  character,
	input  logic        end_of_command,
	input  logic        empty_command,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  reply_code,
	output logic        frame_valid,
	output logic [31:0] frame_id,
	output logic        frame_extended,
	output logic        frame_remote,
	output logic [3:0]  frame_length,
	output logic [63:0] frame_data
);
	import acfcp_pkg::*;

	// Input register stage
	acfcp_item_t   item_s1;
	logic          valid_s1;
	logic          s1_fire;
	logic          in_take;

	// Result register
	acfcp_result_t result_comb;
	acfcp_result_t result_q;
	logic          out_valid_q;
	logic          out_room;
	logic          out_load;

	// The result register has room when empty or when its transaction leaves now
	assign out_room = !out_valid_q || !out_stall;

	// Advance stage 1 unless it carries an end marker and the result register is blocked
	assign s1_fire  = valid_s1 && (!item_s1.end_of_command || out_room);
	assign out_load = s1_fire && item_s1.end_of_command;

	// Hold the input side only while stage 1 cannot advance
	assign in_stall = valid_s1 && !s1_fire;
	assign in_take  = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!valid_s1 || s1_fire) begin
			valid_s1 <= in_take;
		end
	end

	// Capture the payload of each accepted transaction
	always_ff @(posedge clk) begin
		if (in_take) begin
			item_s1.character      <= character;
			item_s1.end_of_command <= end_of_command;
			item_s1.empty_command  <= empty_command;
		end
	end

	// Fold the character into the command state and judge the command
	acfcp_accum u_accum (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (s1_fire),
		.item   (item_s1),
		.result (result_comb)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// Hold the result while the downstream side stalls
	always_ff @(posedge clk) begin
		if (out_load) begin
			result_q <= result_comb;
		end
	end

	assign out_valid      = out_valid_q;
	assign reply_code     = result_q.reply_code;
	assign frame_valid    = result_q.frame_valid;
	assign frame_id       = result_q.frame_id;
	assign frame_extended = result_q.frame_extended;
	assign frame_remote   = result_q.frame_remote;
	assign frame_length   = result_q.frame_length;
	assign frame_data     = result_q.frame_data;

endmodule
